// File: hw/rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the radix digit emitter
// Field widths, register map, reset values, queue geometry and the control
// structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Field and register widths.
  localparam int NUM_W   = 32;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 5;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 5;
  localparam int ALPHA_N = 16;

  // Default for the largest supported radix.
  localparam int MAX_BASE_DEF = 16;

  // A 32-bit magnitude has at most 32 digits (radix 2).
  localparam int MAX_DIGITS = 32;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = IDX_W + 1;

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_CYC = 8;
  localparam int DIV_CYCLES   = NUM_W / BITS_PER_CYC;
  localparam int STEP_W       = $clog2(DIV_CYCLES);

  // Queue between front and back end; depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int SLOT_W = $clog2(QDEPTH);

  // Register map: index of each register, taken from paddr[4:3].
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_LEN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  localparam logic [LEN_W-1:0] RST_BASE_LEN    = 5'd10;
  localparam logic [CFG_W-1:0] RST_DIGITS_LOW  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0] RST_DIGITS_HIGH = 64'h0000000000003938;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  typedef logic [ALPHA_N-1:0][CHAR_W-1:0] alpha_t;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SIGN,
    B_WAIT,
    B_EMIT
  } back_state_t;

  // Descriptor pushed by the front end when a number's digits are complete.
  typedef struct packed {
    logic             push;
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } push_t;

  // Digit write strobe from the front end.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } wr_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic             nonempty;
    logic             full;
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } qstat_t;

endpackage

// File: hw/rtl/rde_if.sv
// ----------------------------------------------------------------------------
// rde_if: streaming channels of the radix digit emitter
// One channel carries numbers in, the other carries characters out; both use
// a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rde_num_if;
  import rde_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface rde_char_if;
  import rde_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// File: hw/rtl/rde_cfg.sv
// ----------------------------------------------------------------------------
// rde_cfg: configuration registers and alphabet check
// APB-style register file for the radix and the digit alphabet, plus the
// combinational test that the alphabet is usable.
// ----------------------------------------------------------------------------
module rde_cfg #(
  parameter int MAX_BASE = rde_pkg::MAX_BASE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rde_pkg::ADDR_W-1:0]  paddr,
  input  logic [rde_pkg::CFG_W-1:0]   pwdata,
  output logic [rde_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  output logic [rde_pkg::LEN_W-1:0]   base_len,
  output rde_pkg::alpha_t             alpha,
  output logic                        alpha_ok
);
  import rde_pkg::*;

  logic [CFG_W-1:0]     digits_low;
  logic [CFG_W-1:0]     digits_high;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_len    <= RST_BASE_LEN;
      digits_low  <= RST_DIGITS_LOW;
      digits_high <= RST_DIGITS_HIGH;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_LEN:    base_len    <= pwdata[LEN_W-1:0];
        REG_DIGITS_LOW:  digits_low  <= pwdata;
        REG_DIGITS_HIGH: digits_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_LEN:    prdata = {{(CFG_W-LEN_W){1'b0}}, base_len};
      REG_DIGITS_LOW:  prdata = digits_low;
      REG_DIGITS_HIGH: prdata = digits_high;
      default:         prdata = '0;
    endcase
  end

  assign alpha = {digits_high, digits_low};

  // Every used character must differ from both signs and from every other
  // used character; all pair compares run side by side.
  always_comb begin
    alpha_ok = (base_len >= LEN_W'(2)) && (base_len <= LEN_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (LEN_W'(i) < base_len) begin
        if (alpha[i] == CH_MINUS || alpha[i] == CH_PLUS) alpha_ok = 1'b0;
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (LEN_W'(j) < base_len && alpha[i] == alpha[j]) alpha_ok = 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/rde_front.sv
// ----------------------------------------------------------------------------
// rde_front: number intake and digit generation
// Accepts a number, drops it when the alphabet is unusable, and otherwise
// divides its magnitude repeatedly by the radix, writing each remainder.
// ----------------------------------------------------------------------------
module rde_front #(
  parameter int MAX_BASE = rde_pkg::MAX_BASE_DEF,
  localparam int DIGIT_W = $clog2(MAX_BASE)
) (
  input  logic                      clk,
  input  logic                      rst,
  rde_num_if.sink                   din,
  input  logic [rde_pkg::LEN_W-1:0] base_len,
  input  logic                      alpha_ok,
  input  rde_pkg::qstat_t           qstat,
  output rde_pkg::push_t            push,
  output rde_pkg::wr_t              wr,
  output logic [DIGIT_W-1:0]        wr_digit
);
  import rde_pkg::*;

  front_state_t        state, state_next;
  logic [NUM_W-1:0]    work, work_next;
  logic [LEN_W-1:0]    rem, rem_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [CNT_W-1:0]    nd, nd_next;
  logic                neg, neg_next;
  logic [LEN_W-1:0]    rem_out;
  logic [BITS_PER_CYC-1:0] qbits;
  logic [NUM_W-1:0]    quot;
  logic                accept;
  logic [NUM_W-1:0]    raw;

  assign din.ready = (state == F_IDLE) && !qstat.full;
  assign accept    = din.valid && din.ready;
  assign raw       = din.number;

  // Restoring division, BITS_PER_CYC quotient bits of the magnitude per cycle.
  always_comb begin
    logic [LEN_W:0]   trial;
    logic [LEN_W-1:0] r;
    r = rem;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      trial = {r, work[NUM_W-1-i]};
      if (trial >= {1'b0, base_len}) begin
        trial = trial - {1'b0, base_len};
        qbits[BITS_PER_CYC-1-i] = 1'b1;
      end else begin
        qbits[BITS_PER_CYC-1-i] = 1'b0;
      end
      r = trial[LEN_W-1:0];
    end
    rem_out = r;
  end

  assign quot = {work[NUM_W-1-BITS_PER_CYC:0], qbits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    work <= work_next;
    rem  <= rem_next;
    step <= step_next;
    nd   <= nd_next;
    neg  <= neg_next;
  end

  always_comb begin
    state_next = state;
    work_next  = work;
    rem_next   = rem;
    step_next  = step;
    nd_next    = nd;
    neg_next   = neg;
    push       = '0;
    wr         = '0;
    wr_digit   = rem_out[DIGIT_W-1:0];
    case (state)
      F_IDLE: begin
        if (accept && alpha_ok) begin
          neg_next   = raw[NUM_W-1];
          work_next  = raw[NUM_W-1] ? (NUM_W'(0) - raw) : raw;
          rem_next   = '0;
          step_next  = '0;
          nd_next    = '0;
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        work_next = quot;
        rem_next  = rem_out;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(DIV_CYCLES - 1)) begin
          // One digit finished: store it, restart the remainder.
          wr.en    = 1'b1;
          wr.idx   = nd[IDX_W-1:0];
          rem_next = '0;
          nd_next  = nd + CNT_W'(1);
          if (quot == '0 || nd == CNT_W'(MAX_DIGITS - 1)) begin
            push.push  = 1'b1;
            push.neg   = neg;
            push.cnt   = nd + CNT_W'(1);
            state_next = F_IDLE;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/rde_queue.sv
// ----------------------------------------------------------------------------
// rde_queue: digit buffer between front and back end
// Holds up to QDEPTH converted numbers: a descriptor per number and a digit
// memory with one slot of MAX_DIGITS entries per descriptor.
// ----------------------------------------------------------------------------
module rde_queue #(
  parameter int MAX_BASE = rde_pkg::MAX_BASE_DEF,
  localparam int DIGIT_W = $clog2(MAX_BASE)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rde_pkg::push_t            push,
  input  rde_pkg::wr_t              wr,
  input  logic [DIGIT_W-1:0]        wr_digit,
  input  logic                      pop,
  input  logic [rde_pkg::IDX_W-1:0] rd_idx,
  output logic [DIGIT_W-1:0]        rd_digit,
  output rde_pkg::qstat_t           qstat
);
  import rde_pkg::*;

  localparam int MEM_DEPTH = QDEPTH * MAX_DIGITS;

  logic [DIGIT_W-1:0] mem [MEM_DEPTH];
  logic               neg_q [QDEPTH];
  logic [CNT_W-1:0]   cnt_q [QDEPTH];
  logic [SLOT_W-1:0]  head, tail;
  logic [SLOT_W:0]    count;

  always_ff @(posedge clk) begin
    if (wr.en) mem[{tail, wr.idx}] <= wr_digit;
    rd_digit <= mem[{head, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      neg_q[tail] <= push.neg;
      cnt_q[tail] <= push.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push.push) tail <= tail + SLOT_W'(1);
      if (pop) head <= head + SLOT_W'(1);
      count <= count + (SLOT_W + 1)'(push.push) - (SLOT_W + 1)'(pop);
    end
  end

  assign qstat.nonempty = (count != '0);
  assign qstat.full     = (count == (SLOT_W + 1)'(QDEPTH));
  assign qstat.neg      = neg_q[head];
  assign qstat.cnt      = cnt_q[head];

endmodule

// File: hw/rtl/rde_back.sv
// ----------------------------------------------------------------------------
// rde_back: character emission
// Takes converted numbers from the queue, emits the sign and then the digits
// most significant first through an output register.
// ----------------------------------------------------------------------------
module rde_back #(
  parameter int MAX_BASE = rde_pkg::MAX_BASE_DEF,
  localparam int DIGIT_W = $clog2(MAX_BASE)
) (
  input  logic                       clk,
  input  logic                       rst,
  rde_char_if.source                 dout,
  input  rde_pkg::alpha_t            alpha,
  input  rde_pkg::qstat_t            qstat,
  input  logic [DIGIT_W-1:0]         rd_digit,
  output logic [rde_pkg::IDX_W-1:0]  rd_idx,
  output logic                       pop
);
  import rde_pkg::*;

  back_state_t       state, state_next;
  logic [IDX_W-1:0]  k, k_next;
  logic              ov, ov_next;
  logic [CHAR_W-1:0] och, och_next;
  logic              olast, olast_next;
  logic              slot_free;

  assign slot_free     = !ov || dout.ready;
  assign rd_idx        = k;
  assign dout.valid    = ov;
  assign dout.char_out = och;
  assign dout.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    och   <= och_next;
    olast <= olast_next;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    och_next   = och;
    olast_next = olast;
    ov_next    = ov && !dout.ready;
    pop        = 1'b0;
    case (state)
      B_IDLE: begin
        if (qstat.nonempty) begin
          k_next     = IDX_W'(qstat.cnt - CNT_W'(1));
          state_next = qstat.neg ? B_SIGN : B_WAIT;
        end
      end
      B_SIGN: begin
        if (slot_free) begin
          och_next   = CH_MINUS;
          olast_next = 1'b0;
          ov_next    = 1'b1;
          state_next = B_WAIT;
        end
      end
      // In this state the digit memory is read at index k; the registered digit is used in B_EMIT.
      B_WAIT: state_next = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          och_next   = alpha[4'(rd_digit)];
          olast_next = (k == '0);
          ov_next    = 1'b1;
          if (k == '0) begin
            pop        = 1'b1;
            state_next = B_IDLE;
          end else begin
            k_next     = k - IDX_W'(1);
            state_next = B_WAIT;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// A number's digits go into the queue as the divider finds them, and its
// descriptor follows with the last digit; then the back end can emit it.
// No new number is taken until the last is in the queue; the divider's chain
// of 8 remainder steps per cycle sets the rate; digits go via B_WAIT, B_EMIT.
// Reset (synchronous, active high): registers return to radix 10 over
// "0123456789", the queue empties; no clearing pass is needed.
// ----------------------------------------------------------------------------
// radix_digit_emitter: signed integer to text in a configurable radix
// Converts each 32-bit number into a '-' for negative values followed by its
// digits, most significant first, using an alphabet held in registers.
// ----------------------------------------------------------------------------
module radix_digit_emitter #(
  parameter int MAX_BASE = rde_pkg::MAX_BASE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  rde_num_if.sink                    din,
  rde_char_if.source                 dout,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rde_pkg::ADDR_W-1:0] paddr,
  input  logic [rde_pkg::CFG_W-1:0]  pwdata,
  output logic [rde_pkg::CFG_W-1:0]  prdata,
  output logic                       pready
);
  import rde_pkg::*;

  localparam int DIGIT_W = $clog2(MAX_BASE);

  // Configuration. The alphabet check is combinational on the registers so
  // that a number taken right after a register write already sees the
  // new alphabet.
  logic [LEN_W-1:0]   base_len;
  alpha_t             alpha;
  logic               alpha_ok;

  // Front end to queue: digit writes and the descriptor of a finished
  // number. Queue to back end: head descriptor and the registered digit.
  push_t              push;
  wr_t                wr;
  logic [DIGIT_W-1:0] wr_digit;
  qstat_t             qstat;
  logic               pop;
  logic [IDX_W-1:0]   rd_idx;
  logic [DIGIT_W-1:0] rd_digit;

  rde_cfg #(.MAX_BASE(MAX_BASE)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .base_len (base_len),
    .alpha    (alpha),
    .alpha_ok (alpha_ok)
  );

  // The front end takes a number only when the queue has a free slot, so a
  // conversion never has to wait for space once it has started. Numbers
  // that meet an unusable alphabet are taken and dropped.
  rde_front #(.MAX_BASE(MAX_BASE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .base_len (base_len),
    .alpha_ok (alpha_ok),
    .qstat    (qstat),
    .push     (push),
    .wr       (wr),
    .wr_digit (wr_digit)
  );

  // The digits come out of the divider least significant first; the queue
  // stores them by index so the back end can read them in reverse.
  rde_queue #(.MAX_BASE(MAX_BASE)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr       (wr),
    .wr_digit (wr_digit),
    .pop      (pop),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .qstat    (qstat)
  );

  // The back end maps digits through the alphabet and holds each character
  // in an output register, so a stalled sink never blocks the divider.
  rde_back #(.MAX_BASE(MAX_BASE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .dout     (dout),
    .alpha    (alpha),
    .qstat    (qstat),
    .rd_digit (rd_digit),
    .rd_idx   (rd_idx),
    .pop      (pop)
  );

endmodule

// File: hw/rtl/rde_checker.sv
// ----------------------------------------------------------------------------
// rde_checker: port-level assertions for the radix digit emitter
// Watches the character channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rde_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_last
);
  import rde_pkg::*;

  // A pending character stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before its transaction");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A sign is never the final character of a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == CH_MINUS |-> !out_last)
    else $error("sign character flagged as last");

  // A sign is always followed by a digit; here no second sign may directly follow a taken one.
  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_char == CH_MINUS
      |=> !(out_valid && out_char == CH_MINUS))
    else $error("two sign characters in a row");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_char  (dout.char_out),
  .out_last  (dout.last)
);

// File: tb/tb_radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter: self-checking regression of the radix digit emitter
// Numbers are streamed in over the number channel while characters are drained
// from the character channel, both sides idling at random. A scoreboard class
// predicts the text of every accepted number from its own copy of the radix
// and alphabet registers, which are rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_radix_digit_emitter;
  import rde_pkg::*;

  // Cycles allowed for a number that produces no text to leave the block
  // before the registers change.
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 320;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_rec_t;

  // Predicts the characters of each number and checks the emitted stream.
  class char_scoreboard;
    logic [LEN_W-1:0] base_len;
    logic [CFG_W-1:0] dig_lo;
    logic [CFG_W-1:0] dig_hi;
    char_rec_t        expected_chars[$];
    int               mismatches;
    int               numbers_seen;
    int               silent_numbers;
    int               chars_checked;

    function new();
      base_len = RST_BASE_LEN;
      dig_lo   = RST_DIGITS_LOW;
      dig_hi   = RST_DIGITS_HIGH;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_BASE_LEN:    base_len = value[LEN_W-1:0];
        REG_DIGITS_LOW:  dig_lo = value;
        REG_DIGITS_HIGH: dig_hi = value;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] glyph(int unsigned i);
      logic [CFG_W-1:0] w;
      w = (i % 16 < 8) ? dig_lo : dig_hi;
      return w[(i % 8) * 8 +: 8];
    endfunction

    // The alphabet is usable only with 2..MAX_BASE distinct characters, none
    // of them a sign.
    function bit alphabet_valid();
      int n;
      n = base_len;
      if (n < 2 || n > MAX_BASE_DEF) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (glyph(i) == CH_MINUS || glyph(i) == CH_PLUS) return 1'b0;
        for (int j = i + 1; j < n; j++)
          if (glyph(j) == glyph(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic signed [NUM_W-1:0] n);
      logic [NUM_W-1:0]  mag;
      logic [NUM_W-1:0]  radix;
      logic [CHAR_W-1:0] digs[MAX_DIGITS];
      int                nd;
      char_rec_t         rec;
      numbers_seen++;
      if (!alphabet_valid()) begin
        silent_numbers++;
        return;
      end
      radix = base_len;
      mag = n;
      if (n[NUM_W-1]) mag = -mag;
      nd = 0;
      do begin
        digs[nd] = glyph(mag % radix);
        nd++;
        mag = mag / radix;
      end while (mag != 0 && nd < MAX_DIGITS);
      if (n[NUM_W-1]) begin
        rec.ch = CH_MINUS;
        rec.last = 1'b0;
        expected_chars.push_back(rec);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        rec.ch = digs[k];
        rec.last = (k == 0);
        expected_chars.push_back(rec);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      char_rec_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected character %h last=%b", ch, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        if (mismatches < MAX_REPORTS)
          $display("character mismatch: expected %h last=%b, got %h last=%b",
                   want.ch, want.last, ch, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  rde_num_if  num_ch ();
  rde_char_if chr_ch ();

  char_scoreboard sb;

  // Per-phase idling: when a flag is clear that side never waits, which gives
  // stretches of back-to-back traffic.
  bit num_idle  = 1'b1;
  bit char_idle = 1'b1;
  int settings  = 0;
  int sent      = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  radix_digit_emitter DUT (
    .clk     (clk),
    .rst     (rst),
    .din     (num_ch),
    .dout    (chr_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge that closes the access cycle, where the predictor follows it.
  task write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Registers change only once the block is idle: every predicted character
  // has come out, and any number with no text has had time to pass through.
  task load_setup(input int len, input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] len_word;
    num_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // Bits above the 5-bit radix field are noise the register must drop.
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(len);
    write_reg(REG_BASE_LEN, len_word);
    write_reg(REG_DIGITS_LOW, lo);
    write_reg(REG_DIGITS_HIGH, hi);
    settings++;
  endtask

  function int draw_wait(bit idle);
    return idle ? int'($urandom_range(0, 12)) : 0;
  endfunction

  // Offers one number and returns at the edge of its transaction. When the
  // next number follows with no gap, valid simply stays high.
  task send_number(input logic signed [NUM_W-1:0] n);
    int gap;
    gap = draw_wait(num_idle);
    if (gap > 0) begin
      num_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= n;
    @(posedge clk);
    while (!num_ch.ready) @(posedge clk);
    sb.note_number(n);
    sent++;
  endtask

  // Distinct, sign-free characters for all sixteen slots; about half the time
  // the slots past the radix get arbitrary bytes, signs included.
  function automatic logic [127:0] make_alphabet(int len);
    logic [127:0] al;
    bit           used[256];
    logic [7:0]   c;
    foreach (used[i]) used[i] = 1'b0;
    used[CH_MINUS] = 1'b1;
    used[CH_PLUS]  = 1'b1;
    for (int i = 0; i < 16; i++) begin
      do c = 8'($urandom_range(0, 255)); while (used[c]);
      used[c] = 1'b1;
      al[i*8 +: 8] = c;
    end
    if ($urandom_range(0, 1) == 1)
      for (int i = len; i < 16; i++) al[i*8 +: 8] = 8'($urandom_range(0, 255));
    return al;
  endfunction

  function automatic logic signed [NUM_W-1:0] pick_number();
    int unsigned r;
    logic signed [NUM_W-1:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh80000000;
          1: v = 32'sh7FFFFFFF;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // One random phase: a fresh register setting, mostly valid, then a burst of
  // numbers under freshly drawn idling on both sides.
  task random_phase(input int count);
    int           len;
    int           pos;
    int           pos2;
    int unsigned  kind;
    logic [127:0] al;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0, 1, 2: len = 2;
      3, 4:    len = 16;
      default: len = $urandom_range(2, 16);
    endcase
    al = make_alphabet(len);
    pos = $urandom_range(0, len - 1);
    do pos2 = $urandom_range(0, len - 1); while (pos2 == pos);
    case (kind)
      0: len = $urandom_range(0, 1);
      1: len = $urandom_range(17, 31);
      2: al[pos*8 +: 8] = ($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS;
      3: al[pos2*8 +: 8] = al[pos*8 +: 8];
      default: ;
    endcase
    load_setup(len, al[63:0], al[127:64]);
    num_idle  = ($urandom_range(0, 3) != 0);
    char_idle = ($urandom_range(0, 3) != 0);
    repeat (count) send_number(pick_number());
  endtask

  // Character sink: when char_idle is set, stalls a random number of cycles before each character,
  // then holds ready until the transaction and hands it to the scoreboard.
  initial begin
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_wait(char_idle);
      if (stall > 0) begin
        chr_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      chr_ch.ready <= 1'b1;
      @(posedge clk);
      while (!chr_ch.valid) @(posedge clk);
      sb.check_char(chr_ch.char_out, chr_ch.last);
    end
  end

  // Watchdog: ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    chr_ch.ready  = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Decimal over the reset alphabet: zero, unit values and both extremes,
    // the most negative value included.
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(32'sh7FFFFFFF);
    send_number(32'sh80000000);
    send_number(10);
    send_number(-10);

    // Binary: the most negative value gives the longest text, 33 characters.
    load_setup(2, 64'h0000000000003130, 64'h0);
    send_number(32'sh80000000);
    send_number(32'sh7FFFFFFF);
    send_number(-1);

    // Radix 16 whose alphabet holds a zero byte and an all-ones byte.
    load_setup(16, 64'h666564636261FF00, 64'h6E6D6C6B6A696867);
    send_number(32'sh80000000);
    send_number(0);
    send_number(32'shDEADBEEF);
    send_number(16);

    // Radix 9 with the upper alphabet word all ones; only its low byte is used.
    load_setup(9, RST_DIGITS_LOW, 64'hFFFFFFFFFFFFFFFF);
    send_number(80);
    send_number(-81);

    // Alphabets too short: no text at all.
    load_setup(1, RST_DIGITS_LOW, RST_DIGITS_HIGH);
    send_number(5);
    load_setup(0, RST_DIGITS_LOW, RST_DIGITS_HIGH);
    send_number(7);

    // Radix above the supported maximum, including the largest field value.
    load_setup(17, RST_DIGITS_LOW, RST_DIGITS_HIGH);
    send_number(1);
    load_setup(31, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    send_number(-1);

    // A plus sign inside the alphabet, then a minus sign in its last slot.
    load_setup(4, 64'h000000002B323130, 64'h0);
    send_number(9);
    load_setup(16, RST_DIGITS_LOW, 64'h2D65646362613938);
    send_number(255);

    // A plus sign just past the radix is not part of the alphabet.
    load_setup(4, 64'h0000002B33323130, 64'h0);
    send_number(-7);

    // Repeated characters: an all-zero low word.
    load_setup(3, 64'h0, 64'h0);
    send_number(2);

    // Random phases until the random quota of numbers has gone in.
    sent = 0;
    while (sent < RANDOM_ITEMS) random_phase($urandom_range(15, 35));

    // Back to the reset setting, then drain.
    load_setup(RST_BASE_LEN, RST_DIGITS_LOW, RST_DIGITS_HIGH);
    send_number(pick_number());
    num_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d numbers (%0d without text), %0d characters, %0d settings",
             sb.numbers_seen, sb.silent_numbers, sb.chars_checked, settings);
    $display("mismatches: %0d, characters still expected: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
